/* hw/rtl/mme_pkg.sv */
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Sizes, operation and register codes, the sequencer state and the tag that
// travels with each multiply-accumulate step.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int MAX_DIM     = 8;
	localparam int ELEM_BITS   = 16;
	localparam int IN_ELEM_BITS = 16;
	localparam int SUM_BITS    = 35;
	localparam int DIM_BITS    = 4;
	localparam int IN_IDX_BITS = 3;
	localparam int CFG_IDX_BITS = 2;
	localparam int CELLS       = MAX_DIM * MAX_DIM;
	localparam int IDX_BITS    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_BITS   = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int PROD_BITS   = 2 * ELEM_BITS;

	localparam logic [DIM_BITS-1:0] DIM_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_LOAD_LEFT  = 2'd0,
		OP_LOAD_RIGHT = 2'd1,
		OP_COMPUTE    = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ROWS_N  = 2'd0,
		REG_INNER_M = 2'd1,
		REG_COLS_L  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} seq_state_t;

	typedef struct packed {
		logic                   first;
		logic                   lastk;
		logic [IN_IDX_BITS-1:0] row;
		logic [IN_IDX_BITS-1:0] col;
		logic                   last_elem;
	} mac_tag_t;

	// Row-major cell address of a MAX_DIM by MAX_DIM store.
	function automatic logic [ADDR_BITS-1:0] cell_addr(
		input logic [IN_IDX_BITS-1:0] r,
		input logic [IN_IDX_BITS-1:0] c
	);
		int sum_v;
		sum_v = int'(r) * MAX_DIM + int'(c);
		return ADDR_BITS'(sum_v);
	endfunction

	// Highest index used for a dimension register: 0 acts as 1, above MAX_DIM as MAX_DIM.
	function automatic logic [IDX_BITS-1:0] dim_last(input logic [DIM_BITS-1:0] v);
		logic [IDX_BITS-1:0] res;
		if (v == '0) begin
			res = '0;
		end else if (v > DIM_BITS'(MAX_DIM)) begin
			res = IDX_BITS'(MAX_DIM - 1);
		end else begin
			res = IDX_BITS'(v - DIM_BITS'(1));
		end
		return res;
	endfunction

	function automatic logic signed [ELEM_BITS-1:0] elem_wrap(
		input logic signed [IN_ELEM_BITS-1:0] e
	);
		return ELEM_BITS'(e);
	endfunction

endpackage

/* hw/rtl/matrix_multiply_engine.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_engine: dense matrix product C = A x B
// Command port: a word is taken when start is high and busy is low.
// operation 0 / 1 writes element into A / B at (row_index, col_index) and
// gives no result; busy stays low, so loads go back to back.
// operation 2 computes C (rows_n by cols_l, inner size inner_m) with one
// shared multiply-accumulate unit, one inner step per cycle; busy is high
// while the product runs and falls in the cycle the last result is shown.
// Results come in row-major order, each on the result ports for exactly one
// cycle with result_strobe high; last marks the final element. The receiver
// cannot stall: results are simply shown. Each inner step passes the store
// read register, the product register and the accumulator, which is
// registered together with result_strobe and the result indices.
// Configuration: cfg_we writes cfg_data into register cfg_index at once
// (0 rows_n, 1 inner_m, 2 cols_l); write it only while the block is idle.
// Reset sets all three dimensions to 8 and the sequencer to idle; the
// element stores are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module matrix_multiply_engine (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [1:0]                              operation,
	input  logic [mme_pkg::IN_IDX_BITS-1:0]         row_index,
	input  logic [mme_pkg::IN_IDX_BITS-1:0]         col_index,
	input  logic signed [mme_pkg::IN_ELEM_BITS-1:0] element,
	input  logic                                    cfg_we,
	input  logic [mme_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [mme_pkg::DIM_BITS-1:0]            cfg_data,
	output logic                                    result_strobe,
	output logic [mme_pkg::IN_IDX_BITS-1:0]         result_row,
	output logic [mme_pkg::IN_IDX_BITS-1:0]         result_col,
	output logic signed [mme_pkg::SUM_BITS-1:0]     sum,
	output logic                                    last
);

	logic [mme_pkg::DIM_BITS-1:0] rows_n_q, inner_m_q, cols_l_q;
	logic                          accept, go, in_range, we_a, we_b;
	logic                          running, pipe_busy, issue;
	mme_pkg::mac_tag_t             tag;
	logic [mme_pkg::ADDR_BITS-1:0] waddr, a_addr, b_addr;
	logic signed [mme_pkg::ELEM_BITS-1:0] wdata, a_word, b_word;
	mme_pkg::op_t                  op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_n_q  <= mme_pkg::DIM_RESET;
			inner_m_q <= mme_pkg::DIM_RESET;
			cols_l_q  <= mme_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (mme_pkg::cfg_reg_t'(cfg_index))
				mme_pkg::REG_ROWS_N:  rows_n_q  <= cfg_data;
				mme_pkg::REG_INNER_M: inner_m_q <= cfg_data;
				mme_pkg::REG_COLS_L:  cols_l_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign op     = mme_pkg::op_t'(operation);
	assign accept = start && !busy;
	assign busy   = running || pipe_busy;

	// Drop loads whose row or column lies outside the store.
	assign in_range = ({1'b0, row_index} < (mme_pkg::IN_IDX_BITS + 1)'(mme_pkg::MAX_DIM))
		&& ({1'b0, col_index} < (mme_pkg::IN_IDX_BITS + 1)'(mme_pkg::MAX_DIM));

	always_comb begin
		we_a = 1'b0;
		we_b = 1'b0;
		go   = 1'b0;
		unique case (op)
			mme_pkg::OP_LOAD_LEFT:  we_a = accept && in_range;
			mme_pkg::OP_LOAD_RIGHT: we_b = accept && in_range;
			mme_pkg::OP_COMPUTE:    go   = accept;
			default: begin
			end
		endcase
	end

	assign waddr = mme_pkg::cell_addr(row_index, col_index);
	assign wdata = mme_pkg::elem_wrap(element);

	mme_store u_left (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (a_addr),
		.rdata (a_word)
	);

	mme_store u_right (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (b_addr),
		.rdata (b_word)
	);

	mme_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.rows_n  (rows_n_q),
		.inner_m (inner_m_q),
		.cols_l  (cols_l_q),
		.running (running),
		.issue   (issue),
		.tag     (tag),
		.a_addr  (a_addr),
		.b_addr  (b_addr)
	);

	mme_mac u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.issue         (issue),
		.tag           (tag),
		.a_word        (a_word),
		.b_word        (b_word),
		.pipe_busy     (pipe_busy),
		.result_strobe (result_strobe),
		.result_row    (result_row),
		.result_col    (result_col),
		.sum           (sum),
		.last          (last)
	);

endmodule

/* hw/rtl/mme_store.sv */
// ----------------------------------------------------------------------------
// mme_store: element store of one matrix
// One write port and one read port, read data registered; not reset.
// ----------------------------------------------------------------------------
module mme_store (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [mme_pkg::ADDR_BITS-1:0]         waddr,
	input  logic signed [mme_pkg::ELEM_BITS-1:0]  wdata,
	input  logic [mme_pkg::ADDR_BITS-1:0]         raddr,
	output logic signed [mme_pkg::ELEM_BITS-1:0]  rdata
);

	logic signed [mme_pkg::ELEM_BITS-1:0] mem_q [mme_pkg::CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/mme_seq.sv */
// ----------------------------------------------------------------------------
// mme_seq: product sequencer
// Walks row, column and inner index, one step per cycle, and issues the
// store read addresses with the tag of each multiply-accumulate step.
// ----------------------------------------------------------------------------
module mme_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  logic [mme_pkg::DIM_BITS-1:0]       rows_n,
	input  logic [mme_pkg::DIM_BITS-1:0]       inner_m,
	input  logic [mme_pkg::DIM_BITS-1:0]       cols_l,
	output logic                               running,
	output logic                               issue,
	output mme_pkg::mac_tag_t                  tag,
	output logic [mme_pkg::ADDR_BITS-1:0]      a_addr,
	output logic [mme_pkg::ADDR_BITS-1:0]      b_addr
);

	mme_pkg::seq_state_t state_q, state_d;
	logic [mme_pkg::IDX_BITS-1:0] r_q, c_q, k_q, r_d, c_d, k_d;
	logic [mme_pkg::IDX_BITS-1:0] n_last_q, m_last_q, l_last_q;
	logic lastk, lastc, lastr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			r_q     <= r_d;
			c_q     <= c_d;
			k_q     <= k_d;
		end
	end

	// Dimensions are frozen for the whole product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_last_q <= '0;
			m_last_q <= '0;
			l_last_q <= '0;
		end else if (go) begin
			n_last_q <= mme_pkg::dim_last(rows_n);
			m_last_q <= mme_pkg::dim_last(inner_m);
			l_last_q <= mme_pkg::dim_last(cols_l);
		end
	end

	assign lastk = (k_q == m_last_q);
	assign lastc = (c_q == l_last_q);
	assign lastr = (r_q == n_last_q);

	always_comb begin
		state_d = state_q;
		r_d     = r_q;
		c_d     = c_q;
		k_d     = k_q;
		issue   = 1'b0;
		unique case (state_q)
			mme_pkg::ST_IDLE: begin
				if (go) begin
					state_d = mme_pkg::ST_RUN;
					r_d     = '0;
					c_d     = '0;
					k_d     = '0;
				end
			end
			mme_pkg::ST_RUN: begin
				issue = 1'b1;
				if (!lastk) begin
					k_d = k_q + 1'b1;
				end else begin
					k_d = '0;
					if (!lastc) begin
						c_d = c_q + 1'b1;
					end else begin
						c_d = '0;
						if (lastr) begin
							state_d = mme_pkg::ST_IDLE;
						end else begin
							r_d = r_q + 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = mme_pkg::ST_IDLE;
			end
		endcase
	end

	assign running       = (state_q == mme_pkg::ST_RUN);
	assign tag.first     = (k_q == '0);
	assign tag.lastk     = lastk;
	assign tag.row       = mme_pkg::IN_IDX_BITS'(r_q);
	assign tag.col       = mme_pkg::IN_IDX_BITS'(c_q);
	assign tag.last_elem = lastr && lastc;

	assign a_addr = mme_pkg::cell_addr(mme_pkg::IN_IDX_BITS'(r_q), mme_pkg::IN_IDX_BITS'(k_q));
	assign b_addr = mme_pkg::cell_addr(mme_pkg::IN_IDX_BITS'(k_q), mme_pkg::IN_IDX_BITS'(c_q));

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		running |-> (k_q <= m_last_q && c_q <= l_last_q && r_q <= n_last_q))
		else $error("sequencer index beyond dimension");

	a_final_step: assert property (@(posedge clk) disable iff (!arst_n)
		issue && tag.lastk && tag.last_elem |=> state_q == mme_pkg::ST_IDLE)
		else $error("sequencer kept running after final step");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(running) |-> (r_q == '0 && c_q == '0 && k_q == '0))
		else $error("product did not start at origin");
`endif

endmodule

/* hw/rtl/mme_mac.sv */
// ----------------------------------------------------------------------------
// mme_mac: shared multiply-accumulate unit
// Registers the product of the two store words, accumulates over the inner
// index and holds each finished element on the result ports for one cycle.
// ----------------------------------------------------------------------------
module mme_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  issue,
	input  mme_pkg::mac_tag_t                     tag,
	input  logic signed [mme_pkg::ELEM_BITS-1:0]  a_word,
	input  logic signed [mme_pkg::ELEM_BITS-1:0]  b_word,
	output logic                                  pipe_busy,
	output logic                                  result_strobe,
	output logic [mme_pkg::IN_IDX_BITS-1:0]       result_row,
	output logic [mme_pkg::IN_IDX_BITS-1:0]       result_col,
	output logic signed [mme_pkg::SUM_BITS-1:0]   sum,
	output logic                                  last
);

	logic                                  v_s1, v_s2;
	mme_pkg::mac_tag_t                     tag_s1, tag_s2;
	logic signed [mme_pkg::PROD_BITS-1:0]  prod_s2;
	logic signed [mme_pkg::SUM_BITS-1:0]   acc_q;
	logic                                  strobe_q;
	logic [mme_pkg::IN_IDX_BITS-1:0]       row_q, col_q;
	logic                                  last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			v_s1     <= issue;
			v_s2     <= v_s1;
			strobe_q <= v_s2 && tag_s2.lastk;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= tag;
		tag_s2  <= tag_s1;
		prod_s2 <= a_word * b_word;
	end

	// Restart on the first inner step, else add; wraps to SUM_BITS.
	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (tag_s2.first) begin
				acc_q <= mme_pkg::SUM_BITS'(prod_s2);
			end else begin
				acc_q <= acc_q + mme_pkg::SUM_BITS'(prod_s2);
			end
		end
		if (v_s2 && tag_s2.lastk) begin
			row_q  <= tag_s2.row;
			col_q  <= tag_s2.col;
			last_q <= tag_s2.last_elem;
		end
	end

	assign pipe_busy     = v_s1 || v_s2;
	assign result_strobe = strobe_q;
	assign result_row    = row_q;
	assign result_col    = col_q;
	assign sum           = acc_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |=> !strobe_q)
		else $error("result word right after final element");

	a_acc_continues: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !tag_s2.first |-> $past(v_s2))
		else $error("accumulation without an element in progress");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && tag_s1.first && v_s2 |-> tag_s2.lastk)
		else $error("new element started before previous one finished");
`endif

endmodule

/* tb/mme_product_checker.sv */
// ----------------------------------------------------------------------------
// mme_product_checker: result predictor and scoreboard for the matrix engine
// Tracks dimension writes and element loads, expands each accepted compute
// word into the expected C elements and checks every strobed result in order.
// ----------------------------------------------------------------------------
module mme_product_checker
	import mme_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [1:0]                     operation,
	input  logic [IN_IDX_BITS-1:0]         row_index,
	input  logic [IN_IDX_BITS-1:0]         col_index,
	input  logic signed [IN_ELEM_BITS-1:0] element,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [DIM_BITS-1:0]            cfg_data,
	input  logic                           result_strobe,
	input  logic [IN_IDX_BITS-1:0]         result_row,
	input  logic [IN_IDX_BITS-1:0]         result_col,
	input  logic signed [SUM_BITS-1:0]     sum,
	input  logic                           last,
	output int                             pending,
	output int                             failures
);

	typedef struct packed {
		logic [IN_IDX_BITS-1:0]     row;
		logic [IN_IDX_BITS-1:0]     col;
		logic signed [SUM_BITS-1:0] dot;
		logic                       last;
	} product_word_t;

	logic [DIM_BITS-1:0] rows_reg;
	logic [DIM_BITS-1:0] inner_reg;
	logic [DIM_BITS-1:0] cols_reg;
	logic signed [ELEM_BITS-1:0] left_cells [CELLS];
	logic signed [ELEM_BITS-1:0] right_cells [CELLS];
	product_word_t expected_products [$];
	int fail_count = 0;

	assign failures = fail_count;

	function automatic int used_dim(input logic [DIM_BITS-1:0] v);
		if (v == '0) return 1;
		if (v > DIM_BITS'(MAX_DIM)) return MAX_DIM;
		return int'(v);
	endfunction

	task automatic queue_product();
		int n;
		int m;
		int l;
		longint acc;
		product_word_t w;
		n = used_dim(rows_reg);
		m = used_dim(inner_reg);
		l = used_dim(cols_reg);
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < l; c++) begin
				acc = 0;
				for (int k = 0; k < m; k++) begin
					acc += longint'(left_cells[r * MAX_DIM + k]) *
						longint'(right_cells[k * MAX_DIM + c]);
				end
				w.row = IN_IDX_BITS'(r);
				w.col = IN_IDX_BITS'(c);
				w.dot = SUM_BITS'(acc);
				w.last = (r == n - 1) && (c == l - 1);
				expected_products.push_back(w);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		product_word_t want;
		if (!arst_n) begin
			rows_reg <= DIM_RESET;
			inner_reg <= DIM_RESET;
			cols_reg <= DIM_RESET;
			expected_products.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_N:  rows_reg <= cfg_data;
					REG_INNER_M: inner_reg <= cfg_data;
					REG_COLS_L:  cols_reg <= cfg_data;
					default: ;
				endcase
			end
			// check before queueing: a new compute may be taken on the last result's edge
			if (result_strobe) begin
				if (expected_products.size() == 0) begin
					$error("result word with nothing expected: row %0d col %0d sum %0d",
						result_row, result_col, sum);
					fail_count++;
				end else begin
					want = expected_products.pop_front();
					if (result_row !== want.row) begin
						$error("result_row: expected %0d, got %0d", want.row, result_row);
						fail_count++;
					end
					if (result_col !== want.col) begin
						$error("result_col: expected %0d, got %0d", want.col, result_col);
						fail_count++;
					end
					if (sum !== want.dot) begin
						$error("sum: expected %0d, got %0d", want.dot, sum);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				case (operation)
					OP_LOAD_LEFT:
						left_cells[row_index * MAX_DIM + col_index] <= ELEM_BITS'(element);
					OP_LOAD_RIGHT:
						right_cells[row_index * MAX_DIM + col_index] <= ELEM_BITS'(element);
					OP_COMPUTE:
						queue_product();
					default: ;
				endcase
			end
			pending <= expected_products.size();
		end
	end

endmodule

/* tb/tb_matrix_multiply_engine.sv */
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine: regression bench for the matrix multiply engine
// Drives directed and random load/compute words through the command port
// under several sender idle rates and dimension settings, fills every cell a
// product reads before computing it, and lets the checker score the results.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine;
	import mme_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 130;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] operation = '0;
	logic [IN_IDX_BITS-1:0] row_index = '0;
	logic [IN_IDX_BITS-1:0] col_index = '0;
	logic signed [IN_ELEM_BITS-1:0] element = '0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [DIM_BITS-1:0] cfg_data = '0;
	logic busy;
	logic result_strobe;
	logic [IN_IDX_BITS-1:0] result_row;
	logic [IN_IDX_BITS-1:0] result_col;
	logic signed [SUM_BITS-1:0] sum;
	logic last;

	int pending;
	int failures;
	int cycle_count = 0;
	int idle_pct = 0;
	int words_sent = 0;
	logic [DIM_BITS-1:0] rows_cfg = DIM_RESET;
	logic [DIM_BITS-1:0] inner_cfg = DIM_RESET;
	logic [DIM_BITS-1:0] cols_cfg = DIM_RESET;
	bit left_loaded [CELLS];
	bit right_loaded [CELLS];

	matrix_multiply_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.row_index(row_index),
		.col_index(col_index),
		.element(element),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.result_row(result_row),
		.result_col(result_col),
		.sum(sum),
		.last(last)
	);

	mme_product_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.row_index(row_index),
		.col_index(col_index),
		.element(element),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.result_row(result_row),
		.result_col(result_col),
		.sum(sum),
		.last(last),
		.pending(pending),
		.failures(failures)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int eff_dim(input logic [DIM_BITS-1:0] v);
		if (v == '0) return 1;
		if (v > DIM_BITS'(MAX_DIM)) return MAX_DIM;
		return int'(v);
	endfunction

	// mostly small sizes, now and then zero, full size or above range
	function automatic logic [DIM_BITS-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIM_BITS'($urandom_range(MAX_DIM + 1, 15));
			2: return DIM_BITS'(MAX_DIM);
			default: return DIM_BITS'($urandom_range(1, 3));
		endcase
	endfunction

	function automatic logic signed [IN_ELEM_BITS-1:0] rand_element();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return IN_ELEM_BITS'($urandom);
		endcase
	endfunction

	// Hold the word on the port until the block takes it; start stays high on return.
	task automatic send_word(
		input logic [1:0] op,
		input logic [IN_IDX_BITS-1:0] r,
		input logic [IN_IDX_BITS-1:0] c,
		input logic signed [IN_ELEM_BITS-1:0] e
	);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		row_index <= r;
		col_index <= c;
		element <= e;
		if (op == OP_LOAD_LEFT) left_loaded[r * MAX_DIM + c] = 1'b1;
		if (op == OP_LOAD_RIGHT) right_loaded[r * MAX_DIM + c] = 1'b1;
		words_sent++;
		do @(posedge clk); while (busy);
	endtask

	// Wait until the block is idle and every result is in.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (busy || pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_dims(
		input logic [DIM_BITS-1:0] n,
		input logic [DIM_BITS-1:0] m,
		input logic [DIM_BITS-1:0] l,
		input bit poke_spare
	);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS_N;
		cfg_data <= n;
		@(posedge clk);
		cfg_index <= REG_INNER_M;
		cfg_data <= m;
		@(posedge clk);
		cfg_index <= REG_COLS_L;
		cfg_data <= l;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= DIM_BITS'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		rows_cfg = n;
		inner_cfg = m;
		cols_cfg = l;
	endtask

	// Load every cell the product reads that was never written, then compute.
	task automatic run_product();
		int n;
		int m;
		int l;
		n = eff_dim(rows_cfg);
		m = eff_dim(inner_cfg);
		l = eff_dim(cols_cfg);
		for (int r = 0; r < n; r++) begin
			for (int k = 0; k < m; k++) begin
				if (!left_loaded[r * MAX_DIM + k])
					send_word(OP_LOAD_LEFT, IN_IDX_BITS'(r), IN_IDX_BITS'(k), rand_element());
			end
		end
		for (int k = 0; k < m; k++) begin
			for (int c = 0; c < l; c++) begin
				if (!right_loaded[k * MAX_DIM + c])
					send_word(OP_LOAD_RIGHT, IN_IDX_BITS'(k), IN_IDX_BITS'(c), rand_element());
			end
		end
		send_word(OP_COMPUTE, IN_IDX_BITS'($urandom), IN_IDX_BITS'($urandom), rand_element());
	endtask

	initial begin
		int round;
		int n;
		int m;
		int l;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2x2 product of extreme values, far-corner loads, an unused opcode, an overwrite
		program_dims(4'd2, 4'd2, 4'd2, 1'b0);
		send_word(OP_LOAD_LEFT, 3'd0, 3'd0, 16'sh7fff);
		send_word(OP_LOAD_LEFT, 3'd0, 3'd1, 16'sh8000);
		send_word(OP_LOAD_LEFT, 3'd1, 3'd0, 16'sh8000);
		send_word(OP_LOAD_LEFT, 3'd1, 3'd1, -16'sd1);
		send_word(OP_LOAD_RIGHT, 3'd0, 3'd0, 16'sh8000);
		send_word(OP_LOAD_RIGHT, 3'd0, 3'd1, 16'sh7fff);
		send_word(OP_LOAD_RIGHT, 3'd1, 3'd0, 16'sh8000);
		send_word(OP_LOAD_RIGHT, 3'd1, 3'd1, 16'sd0);
		send_word(OP_LOAD_LEFT, 3'd7, 3'd7, rand_element());
		send_word(OP_LOAD_RIGHT, 3'd7, 3'd7, rand_element());
		send_word(OP_NONE, IN_IDX_BITS'($urandom), IN_IDX_BITS'($urandom), rand_element());
		send_word(OP_COMPUTE, 3'd7, 3'd7, 16'sh7fff);
		send_word(OP_LOAD_LEFT, 3'd0, 3'd0, 16'sd1);
		send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sd0);

		round = 0;
		while (words_sent < RANDOM_WORDS) begin
			case (round % 3)
				0: idle_pct = 0;
				1: idle_pct = 51;
				default: idle_pct = 31;
			endcase
			drain();
			case (round)
				0: program_dims(4'd0, 4'd15, 4'd9, 1'b1);
				4: program_dims(4'd8, 4'd8, 4'd8, 1'b0);
				default: program_dims(pick_dim(), pick_dim(), pick_dim(),
					$urandom_range(0, 3) == 0);
			endcase
			n = eff_dim(rows_cfg);
			m = eff_dim(inner_cfg);
			l = eff_dim(cols_cfg);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3:
						send_word(OP_LOAD_LEFT, IN_IDX_BITS'($urandom_range(0, n - 1)),
							IN_IDX_BITS'($urandom_range(0, m - 1)), rand_element());
					4, 5, 6:
						send_word(OP_LOAD_RIGHT, IN_IDX_BITS'($urandom_range(0, m - 1)),
							IN_IDX_BITS'($urandom_range(0, l - 1)), rand_element());
					7, 8:
						send_word(($urandom_range(0, 1) == 0) ? OP_LOAD_LEFT : OP_LOAD_RIGHT,
							IN_IDX_BITS'($urandom), IN_IDX_BITS'($urandom), rand_element());
					default:
						send_word(OP_NONE, IN_IDX_BITS'($urandom), IN_IDX_BITS'($urandom),
							rand_element());
				endcase
			end
			run_product();
			round++;
		end

		drain();
		repeat (16) @(posedge clk);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
